/* hdl/hspq_pkg.sv */
package hspq_pkg;
	localparam int DEPTH = 32;
	localparam int KEY_WIDTH = 32;
	localparam int HANDLE_WIDTH = 9;
	localparam int CNT_WIDTH = $clog2(DEPTH + 1);
	localparam int IDX_WIDTH = $clog2(DEPTH);

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_BUILD = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [HANDLE_WIDTH-1:0] FIRST_INTERNAL = HANDLE_WIDTH'(256);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_REM_OUT,
		S_POP1,
		S_POP2,
		S_SUM,
		S_MERGE,
		S_ROOT
	} state_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_STATUS,
		RES_POP,
		RES_ROOT
	} res_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;       // capture input item
		logic do_insert;     // insert staged key/handle
		logic do_pop;        // pop head
		logic pop_to_a;      // pop into A (else B)
		logic merge_stage;   // stage saturating sum of A,B with new handle
		logic out_load;      // load output register
		logic [1:0] out_status;
		logic out_merge;
		logic out_last;
		res_sel_t out_sel;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CNT_WIDTH-1:0] count;
		logic [1:0] mode;
		logic out_busy;
	} stat_t;
endpackage

/* hdl/hspq_datapath.sv */
module hspq_datapath import hspq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output stat_t stat,
	input  logic [1:0] mode,
	input  logic [KEY_WIDTH-1:0] key_in,
	input  logic [HANDLE_WIDTH-1:0] handle_in,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic [HANDLE_WIDTH-1:0] handle_out,
	output logic [KEY_WIDTH-1:0] key_out,
	output logic [HANDLE_WIDTH-1:0] left_child,
	output logic [HANDLE_WIDTH-1:0] right_child,
	output logic is_merge,
	output logic last
);
	// sorted shift array, each position compares itself with the new key
	logic [KEY_WIDTH-1:0] keys_q [DEPTH];
	logic [HANDLE_WIDTH-1:0] hdls_q [DEPTH];
	logic [CNT_WIDTH-1:0] count_q;
	logic [HANDLE_WIDTH-1:0] next_h_q;
	logic [1:0] mode_q;
	logic [KEY_WIDTH-1:0] ins_key_q, a_key_q, b_key_q;
	logic [HANDLE_WIDTH-1:0] ins_h_q, a_h_q, b_h_q;
	logic [DEPTH-1:0] lt;
	logic [DEPTH-1:0] lt_up;
	logic [KEY_WIDTH:0] sum;

	always_comb begin
		for (int i = 0; i < DEPTH; i++)
			lt[i] = (CNT_WIDTH'(i) < count_q) && (keys_q[i] < ins_key_q);
		// compare result of the position below; position 0 has none
		lt_up = {lt[DEPTH-2:0], 1'b1};
		sum = {1'b0, a_key_q} + {1'b0, b_key_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.do_insert) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!lt[i]) begin
					if (lt_up[i]) begin
						keys_q[i] <= ins_key_q;
						hdls_q[i] <= ins_h_q;
					end else begin
						keys_q[i] <= keys_q[i-1];
						hdls_q[i] <= hdls_q[i-1];
					end
				end
			end
		end else if (cmd.do_pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				keys_q[i] <= keys_q[i+1];
				hdls_q[i] <= hdls_q[i+1];
			end
		end
		if (cmd.load_in) begin
			ins_key_q <= key_in;
			ins_h_q <= handle_in;
		end else if (cmd.merge_stage) begin
			ins_key_q <= sum[KEY_WIDTH] ? '1 : sum[KEY_WIDTH-1:0];
			ins_h_q <= next_h_q;
		end
		if (cmd.do_pop && cmd.pop_to_a) begin
			a_key_q <= keys_q[0];
			a_h_q <= hdls_q[0];
		end
		if (cmd.do_pop && !cmd.pop_to_a) begin
			b_key_q <= keys_q[0];
			b_h_q <= hdls_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			next_h_q <= FIRST_INTERNAL;
			mode_q <= MODE_INSERT;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load_in)
				mode_q <= mode;
			if (cmd.do_insert)
				count_q <= count_q + 1'b1;
			else if (cmd.do_pop)
				count_q <= count_q - 1'b1;
			if (cmd.merge_stage)
				next_h_q <= next_h_q + 1'b1;
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status <= cmd.out_status;
			is_merge <= cmd.out_merge;
			last <= cmd.out_last;
			handle_out <= '0;
			key_out <= '0;
			left_child <= '0;
			right_child <= '0;
			case (cmd.out_sel)
				RES_POP: begin
					handle_out <= a_h_q;
					key_out <= a_key_q;
				end
				RES_ROOT: begin
					handle_out <= hdls_q[0];
					key_out <= keys_q[0];
				end
				RES_STATUS: ;
				default: ;
			endcase
			if (cmd.out_merge) begin
				handle_out <= ins_h_q;
				key_out <= ins_key_q;
				left_child <= a_h_q;
				right_child <= b_h_q;
			end
		end
	end

	assign stat.count = count_q;
	assign stat.mode = mode_q;
	assign stat.out_busy = out_valid && !out_ready;
endmodule

/* hdl/hspq_ctrl.sv */
module hspq_ctrl import hspq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  stat_t stat,
	output logic in_ready,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.out_sel = RES_NONE;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load_in = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				// decide per mode, wait for output slot
				if (!stat.out_busy) begin
					case (stat.mode)
						MODE_INSERT: begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							cmd.out_sel = RES_STATUS;
							if (stat.count == CNT_WIDTH'(DEPTH)) begin
								cmd.out_status = ST_FULL;
							end else begin
								cmd.do_insert = 1'b1;
							end
							state_d = S_IDLE;
						end
						MODE_REMOVE: begin
							if (stat.count == '0) begin
								cmd.out_load = 1'b1;
								cmd.out_last = 1'b1;
								cmd.out_status = ST_EMPTY;
								cmd.out_sel = RES_STATUS;
								state_d = S_IDLE;
							end else begin
								cmd.do_pop = 1'b1;
								cmd.pop_to_a = 1'b1;
								state_d = S_REM_OUT;
							end
						end
						MODE_BUILD: begin
							if (stat.count == '0) begin
								cmd.out_load = 1'b1;
								cmd.out_last = 1'b1;
								cmd.out_status = ST_EMPTY;
								cmd.out_sel = RES_STATUS;
								state_d = S_IDLE;
							end else if (stat.count == CNT_WIDTH'(1)) begin
								cmd.out_load = 1'b1;
								cmd.out_last = 1'b1;
								cmd.out_sel = RES_ROOT;
								state_d = S_IDLE;
							end else begin
								state_d = S_POP1;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_REM_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.out_sel = RES_POP;
					state_d = S_IDLE;
				end
			end
			S_POP1: begin
				cmd.do_pop = 1'b1;
				cmd.pop_to_a = 1'b1;
				state_d = S_POP2;
			end
			S_POP2: begin
				cmd.do_pop = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.merge_stage = 1'b1;
				state_d = S_MERGE;
			end
			S_MERGE: begin
				// report the merge and insert the merged node together
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					cmd.out_merge = 1'b1;
					cmd.do_insert = 1'b1;
					if (stat.count == '0)
						state_d = S_ROOT;
					else
						state_d = S_POP1;
				end
			end
			S_ROOT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.out_sel = RES_ROOT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* hdl/huffman_sorted_priority_queue.sv */
// Sorted priority queue for Huffman tree building; one item in flight.
// Insert: status result and insert in the same decode step; remove: pop, then the popped result.
// Build of n >= 2 entries: n-1 merge results, each after two pops, a saturating add and an
// insert, then the root; an empty build returns ST_EMPTY, a single-entry build the root.
// Output back-pressure stalls each result until it is taken. Reset: queue empty, handle counter 256.
module huffman_sorted_priority_queue import hspq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [47:0] s_tdata,  // mode[1:0], key_in[33:2], handle_in[42:34]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [63:0] m_tdata,  // status[1:0], handle_out[10:2], key_out[42:11],
	                              // left_child[51:43], right_child[60:52], is_merge[61]
	output logic m_tlast
);
	cmd_t cmd;
	stat_t stat;
	logic [1:0] status;
	logic [HANDLE_WIDTH-1:0] handle_out, left_child, right_child;
	logic [KEY_WIDTH-1:0] key_out;
	logic is_merge;

	hspq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready),
		.stat(stat), .in_ready(s_tready), .cmd(cmd)
	);

	hspq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.mode(s_tdata[1:0]), .key_in(s_tdata[33:2]), .handle_in(s_tdata[42:34]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.status(status), .handle_out(handle_out), .key_out(key_out),
		.left_child(left_child), .right_child(right_child),
		.is_merge(is_merge), .last(m_tlast)
	);

	assign m_tdata = {2'b0, is_merge, right_child, left_child, key_out, handle_out, status};
endmodule

/* tb/tb.sv */
module tb;
	import hspq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] status;
		logic [HANDLE_WIDTH-1:0] handle;
		logic [KEY_WIDTH-1:0] key;
		logic [HANDLE_WIDTH-1:0] left;
		logic [HANDLE_WIDTH-1:0] right;
		logic merge;
		logic last;
	} qres_t;

	class huff_scoreboard;
		logic [KEY_WIDTH-1:0] keys[DEPTH];
		logic [HANDLE_WIDTH-1:0] hdls[DEPTH];
		int count;
		logic [HANDLE_WIDTH-1:0] next_h;
		qres_t pending[$];
		int errors;

		function new();
			count = 0;
			next_h = FIRST_INTERNAL;
			errors = 0;
		endfunction

		function void push_res(logic [1:0] st, logic [HANDLE_WIDTH-1:0] h,
				logic [KEY_WIDTH-1:0] k, logic [HANDLE_WIDTH-1:0] l,
				logic [HANDLE_WIDTH-1:0] r, logic mg, logic lt);
			qres_t x;
			x.status = st; x.handle = h; x.key = k; x.left = l; x.right = r;
			x.merge = mg; x.last = lt;
			pending.push_back(x);
		endfunction

		function void q_insert(logic [KEY_WIDTH-1:0] k, logic [HANDLE_WIDTH-1:0] h);
			int pos;
			pos = 0;
			while (pos < count && keys[pos] < k)
				pos++;
			for (int i = count; i > pos; i--) begin
				keys[i] = keys[i-1];
				hdls[i] = hdls[i-1];
			end
			keys[pos] = k;
			hdls[pos] = h;
			count++;
		endfunction

		function void q_pop(output logic [KEY_WIDTH-1:0] k, output logic [HANDLE_WIDTH-1:0] h);
			k = keys[0];
			h = hdls[0];
			for (int i = 1; i < count; i++) begin
				keys[i-1] = keys[i];
				hdls[i-1] = hdls[i];
			end
			count--;
		endfunction

		function void note_item(logic [1:0] mode, logic [KEY_WIDTH-1:0] k,
				logic [HANDLE_WIDTH-1:0] h);
			logic [KEY_WIDTH-1:0] k1, k2;
			logic [HANDLE_WIDTH-1:0] h1, h2;
			logic [KEY_WIDTH:0] sum;
			if (mode == MODE_INSERT) begin
				if (count >= DEPTH)
					push_res(ST_FULL, '0, '0, '0, '0, 1'b0, 1'b1);
				else begin
					q_insert(k, h);
					push_res(ST_OK, '0, '0, '0, '0, 1'b0, 1'b1);
				end
			end else if (mode == MODE_REMOVE) begin
				if (count == 0)
					push_res(ST_EMPTY, '0, '0, '0, '0, 1'b0, 1'b1);
				else begin
					q_pop(k1, h1);
					push_res(ST_OK, h1, k1, '0, '0, 1'b0, 1'b1);
				end
			end else if (mode == MODE_BUILD) begin
				if (count == 0)
					push_res(ST_EMPTY, '0, '0, '0, '0, 1'b0, 1'b1);
				else begin
					while (count >= 2) begin
						q_pop(k1, h1);
						q_pop(k2, h2);
						sum = k1 + k2;
						if (sum[KEY_WIDTH])
							sum = {1'b0, {KEY_WIDTH{1'b1}}};
						q_insert(sum[KEY_WIDTH-1:0], next_h);
						push_res(ST_OK, next_h, sum[KEY_WIDTH-1:0], h1, h2, 1'b1, 1'b0);
						next_h++;
					end
					push_res(ST_OK, hdls[0], keys[0], '0, '0, 1'b0, 1'b1);
				end
			end
		endfunction

		function void check_result(logic [63:0] d, logic lt);
			qres_t e;
			if (pending.size() == 0) begin
				report_err("result with nothing expected");
				return;
			end
			e = pending.pop_front();
			if (d[1:0] !== e.status) report_err("status");
			if (d[10:2] !== e.handle) report_err("handle_out");
			if (d[42:11] !== e.key) report_err("key_out");
			if (d[51:43] !== e.left) report_err("left_child");
			if (d[60:52] !== e.right) report_err("right_child");
			if (d[61] !== e.merge) report_err("is_merge");
			if (lt !== e.last) report_err("last");
		endfunction

		function void report_err(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [63:0] m_tdata;
	logic m_tlast;

	huff_scoreboard sb;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	bit sink_hold = 0;

	always #5 clk = ~clk;

	huffman_sorted_priority_queue uut (.*);

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_item(s_tdata[1:0], s_tdata[33:2], s_tdata[42:34]);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
	end

	// receiver
	initial begin
		forever begin
			@(negedge clk);
			if (!arst_n)
				m_tready <= 0;
			else if (sink_hold)
				m_tready <= 0;
			else
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_item(logic [1:0] mode, logic [KEY_WIDTH-1:0] k,
			logic [HANDLE_WIDTH-1:0] h);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'b0, h, k, mode};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_src();
		s_tvalid <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		idle_src();
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [KEY_WIDTH-1:0] rnd_key();
		case ($urandom_range(3))
			0: return $urandom_range(15);
			1: return {KEY_WIDTH{1'b1}} - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic rnd_phase(int n);
		int m;
		for (int i = 0; i < n; i++) begin
			m = $urandom_range(99);
			if (m < 50)
				send_item(MODE_INSERT, rnd_key(), 9'($urandom_range(511)));
			else if (m < 80)
				send_item(MODE_REMOVE, $urandom, 9'($urandom_range(511)));
			else if (m < 92)
				send_item(MODE_BUILD, $urandom, 9'($urandom_range(511)));
			else if (m < 96)
				send_item(MODE_NONE, $urandom, 9'($urandom_range(511)));
			else begin
				// a small tree over the queued entries plus new ones, then its root removed
				for (int j = $urandom_range(1, 6); j > 0; j--)
					send_item(MODE_INSERT, $urandom_range(40), 9'($urandom_range(255)));
				send_item(MODE_BUILD, '0, '0);
				send_item(MODE_REMOVE, '0, '0);
			end
		end
	endtask

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		sb = new();
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: empty cases, extremes, build, remove
		send_item(MODE_REMOVE, '0, '0);
		send_item(MODE_BUILD, '0, '0);
		send_item(MODE_NONE, '1, '1);
		send_item(MODE_INSERT, '1, '1);
		send_item(MODE_INSERT, '1, 9'd0);
		send_item(MODE_BUILD, '0, '0);
		send_item(MODE_BUILD, '0, '0);
		send_item(MODE_REMOVE, '0, '0);
		send_item(MODE_INSERT, '0, 9'd255);
		send_item(MODE_INSERT, '0, 9'd1);
		send_item(MODE_INSERT, 32'h5555_5555, 9'h0AA);
		send_item(MODE_INSERT, 32'hAAAA_AAAA, 9'h155);
		send_item(MODE_BUILD, '0, '0);
		send_item(MODE_REMOVE, '0, '0);
		drain();
		// fill past full with long receiver hold-off
		fork
			begin
				sink_hold = 1;
				repeat (300) @(negedge clk);
				sink_hold = 0;
			end
			for (int i = 0; i < DEPTH + 2; i++)
				send_item(MODE_INSERT, $urandom_range(1000), 9'($urandom_range(511)));
		join
		send_item(MODE_BUILD, '0, '0);
		send_item(MODE_REMOVE, '0, '0);
		drain();
		src_idle_pct = 11; sink_idle_pct = 73;
		rnd_phase(90);
		drain();
		src_idle_pct = 73; sink_idle_pct = 11;
		rnd_phase(90);
		drain();
		src_idle_pct = 0; sink_idle_pct = 0;
		rnd_phase(90);
		drain();
		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
